### rtl/ncc_pkg.sv
// Shared types and constants of the nearest centroid classifier.
`timescale 1ns / 1ps

package ncc_pkg;

    localparam int BAND_COUNT  = 4;
    localparam int LABEL_LIMIT = 16;
    localparam int LABEL_W     = 5;
    localparam int CLUSTER_W   = 4;
    localparam int BAND_W      = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_CLUSTERS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_COUNT   = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FLUSH,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 final_step;
        logic [CLUSTER_W-1:0] cluster;
        logic [BAND_W-1:0]    band;
    } step_tag_t;

endpackage

### rtl/nearest_centroid_classifier.sv
// Nearest centroid classifier top level: sequencer, config registers, output register.
// Load word: then one feature written per cycle, min(4, MAX_FEATURES) features; next word accepted back in idle.
// Classify word: m_tvalid rises when the label is pushed, and the next word is accepted after that
// push; the pace is set by the single distance unit stepping one feature of one centre per cycle,
// s_tready low meanwhile and longer while a label held by m_tready blocks the push.
// Synchronous active-low reset: active_clusters = 1, feature_count = 4, centre store not cleared.
`timescale 1ns / 1ps

module nearest_centroid_classifier
    import ncc_pkg::*;
#(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_FEATURES = 4,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [71:0]            s_tdata,   // centre_slot[3:0], band_0..band_3 (16 each), pad
    input  logic [0:0]             s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // class_label[4:0], pad
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLUSTER_LIMIT = (MAX_CLUSTERS < LABEL_LIMIT) ? MAX_CLUSTERS : LABEL_LIMIT;
    localparam int FEATURE_LIMIT = (MAX_FEATURES < BAND_COUNT) ? MAX_FEATURES : BAND_COUNT;

    state_t state_reg, state_next;

    logic [4:0]             active_clusters_reg;
    logic [2:0]             feature_count_reg;
    logic [CLUSTER_W-1:0]   slot_reg;
    logic [SAMPLE_BITS-1:0] band_reg [BAND_COUNT];
    logic [CLUSTER_W-1:0]   k_reg, k_next;
    logic [BAND_W-1:0]      j_reg, j_next;
    logic                   m_tvalid_reg;
    logic [LABEL_W-1:0]     label_reg;

    logic [4:0]                        nc_eff;
    logic [2:0]                        nf_eff;
    logic [CLUSTER_W-1:0]              nc_last;
    logic [BAND_W-1:0]                 nf_last;
    logic                              s_accept, out_free;
    logic                              store_we, slot_ok;
    logic [AW-1:0]                     store_waddr, store_raddr;
    logic [SAMPLE_BITS-1:0]            store_rdata;
    logic [BAND_COUNT*SAMPLE_BITS-1:0] sample_flat;
    step_tag_t                         issue_tag;
    logic [CLUSTER_W-1:0]              best_cluster;
    logic                              dist_done;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign slot_ok  = int'(slot_reg) < MAX_CLUSTERS;

    always_comb begin
        nc_eff = active_clusters_reg;
        if (nc_eff == 5'd0) begin
            nc_eff = 5'd1;
        end else if (nc_eff > 5'(CLUSTER_LIMIT)) begin
            nc_eff = 5'(CLUSTER_LIMIT);
        end
        nf_eff = feature_count_reg;
        if (nf_eff == 3'd0) begin
            nf_eff = 3'd1;
        end else if (nf_eff > 3'(FEATURE_LIMIT)) begin
            nf_eff = 3'(FEATURE_LIMIT);
        end
        nc_last = CLUSTER_W'(nc_eff - 5'd1);
        nf_last = BAND_W'(nf_eff - 3'd1);
    end

    always_comb begin
        for (int i = 0; i < BAND_COUNT; i++) begin
            sample_flat[i*SAMPLE_BITS +: SAMPLE_BITS] = band_reg[i];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser[0] == OP_CLASSIFY) ? ST_RUN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (int'(j_reg) == FEATURE_LIMIT - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (j_reg == nf_last && k_reg == nc_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (dist_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        s_tready  = 1'b0;
        store_we  = 1'b0;
        issue_tag = '0;
        k_next    = k_reg;
        j_next    = j_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                k_next   = '0;
                j_next   = '0;
            end
            ST_LOAD: begin
                store_we = slot_ok;
                j_next   = j_reg + BAND_W'(1);
            end
            ST_RUN: begin
                issue_tag.valid      = 1'b1;
                issue_tag.first      = (j_reg == '0);
                issue_tag.last       = (j_reg == nf_last);
                issue_tag.final_step = (j_reg == nf_last) && (k_reg == nc_last);
                issue_tag.cluster    = k_reg;
                issue_tag.band       = j_reg;
                if (j_reg == nf_last) begin
                    j_next = '0;
                    k_next = k_reg + CLUSTER_W'(1);
                end else begin
                    j_next = j_reg + BAND_W'(1);
                end
            end
            ST_FLUSH: begin
            end
            ST_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    assign store_waddr = AW'(int'(slot_reg) * MAX_FEATURES + int'(j_reg));
    assign store_raddr = AW'(int'(k_reg) * MAX_FEATURES + int'(j_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            active_clusters_reg <= 5'd1;
            feature_count_reg   <= 3'd4;
            m_tvalid_reg        <= 1'b0;
            k_reg               <= '0;
            j_reg               <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ACTIVE_CLUSTERS) begin
                    active_clusters_reg <= cfg_data[4:0];
                end else if (cfg_index == CFG_FEATURE_COUNT) begin
                    feature_count_reg <= cfg_data[2:0];
                end
            end
            if (state_reg == ST_PUSH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot_reg <= s_tdata[3:0];
            for (int i = 0; i < BAND_COUNT; i++) begin
                band_reg[i] <= s_tdata[4 + 16*i +: SAMPLE_BITS];
            end
        end
        if (state_reg == ST_PUSH && out_free) begin
            label_reg <= LABEL_W'(best_cluster) + LABEL_W'(1);
        end
    end

    ncc_centre_store #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (band_reg[j_reg]),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    ncc_dist_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue_tag    (issue_tag),
        .centre_data  (store_rdata),
        .sample       (sample_flat),
        .best_cluster (best_cluster),
        .done         (dist_done)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, label_reg};

`ifndef NO_ASSERTIONS
    a_done_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_done |-> state_reg == ST_FLUSH)
        else $error("distance unit finished outside flush");

    a_write_only_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |-> state_reg == ST_LOAD)
        else $error("centre store written outside a load");

    a_label_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (label_reg >= 5'd1) && (label_reg <= 5'(CLUSTER_LIMIT)))
        else $error("class label out of range");
`endif

endmodule

### rtl/ncc_centre_store.sv
// Centre store: one write port, one registered read port.
`timescale 1ns / 1ps

module ncc_centre_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ncc_dist_unit.sv
// Shared distance unit: absolute difference, square, accumulate, and best-centre compare.
`timescale 1ns / 1ps

module ncc_dist_unit
    import ncc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  step_tag_t                         issue_tag,
    input  logic [SAMPLE_BITS-1:0]            centre_data,
    input  logic [BAND_COUNT*SAMPLE_BITS-1:0] sample,
    output logic [CLUSTER_W-1:0]              best_cluster,
    output logic                              done
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int ACC_W = SQ_W + 2;

    step_tag_t              tag1_reg, tag2_reg;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [ACC_W-1:0]       acc_reg, total;
    logic [ACC_W-1:0]       best_reg;
    logic [CLUSTER_W-1:0]   best_cluster_reg;
    logic                   done_reg;
    logic [SAMPLE_BITS-1:0] band_value, diff;
    logic                   take_best;

    always_comb begin
        band_value = sample[tag1_reg.band * SAMPLE_BITS +: SAMPLE_BITS];
        diff = (band_value >= centre_data) ? band_value - centre_data
                                           : centre_data - band_value;
        sq_next = SQ_W'(diff) * SQ_W'(diff);
    end

    always_comb begin
        total = tag2_reg.first ? ACC_W'(sq_reg) : acc_reg + ACC_W'(sq_reg);
        take_best = tag2_reg.valid && tag2_reg.last &&
                    ((tag2_reg.cluster == '0) || (total < best_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
            done_reg <= tag2_reg.valid && tag2_reg.final_step;
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg <= sq_next;
        if (tag2_reg.valid) begin
            acc_reg <= total;
        end
        if (take_best) begin
            best_reg         <= total;
            best_cluster_reg <= tag2_reg.cluster;
        end
    end

    assign best_cluster = best_cluster_reg;
    assign done         = done_reg;

`ifndef NO_ASSERTIONS
    a_final_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        tag2_reg.valid && tag2_reg.final_step |-> tag2_reg.last)
        else $error("final step of a sample is not the last band of a centre");

    a_done_follows_final: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(tag2_reg.valid) && $past(tag2_reg.final_step))
        else $error("done raised without a final step");

    a_best_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        take_best |=> best_cluster_reg == $past(tag2_reg.cluster))
        else $error("best centre not captured");
`endif

endmodule
